/* rtl/bmf1_pkg.sv */
// Package: shared widths, pixel codes, count snapshot type and helpers for the F1 score block.
package bmf1_pkg;

  localparam int unsigned PIX_W   = 8;
  localparam int unsigned CNT_W   = 23;
  localparam int unsigned ACC_W   = 21;
  localparam int unsigned SCORE_W = 17;
  localparam int unsigned QUO_W   = 16;
  localparam int unsigned NUM_W   = CNT_W + 1;
  localparam int unsigned DEN_W   = CNT_W + 2;
  localparam int unsigned REM_W   = DEN_W + 1;

  localparam logic [PIX_W-1:0] POS_VAL = 8'd0;
  localparam logic [PIX_W-1:0] NEG_VAL = 8'd255;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
  localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};

  typedef struct packed {
    logic [CNT_W-1:0] tp;
    logic [CNT_W-1:0] fp;
    logic [CNT_W-1:0] fn;
    logic             last_img;
  } counts_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
    return (c == CNT_MAX) ? c : c + 1'b1;
  endfunction

  function automatic logic [CNT_W-1:0] at_least_one(input logic [CNT_W-1:0] c);
    return (c == '0) ? CNT_W'(1) : c;
  endfunction

endpackage

/* rtl/bmf1_if.sv */
// Interfaces: pixel pair input channel and score result channel.
interface bmf1_in_if
  import bmf1_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pred_pixel;
  logic [PIX_W-1:0] target_pixel;
  logic             last_in_image;
  logic             last_image;

  modport source (output valid, pred_pixel, target_pixel, last_in_image, last_image,
                  input ready);
  modport sink   (input valid, pred_pixel, target_pixel, last_in_image, last_image,
                  output ready);
endinterface

interface bmf1_out_if
  import bmf1_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [SCORE_W-1:0] image_score;
  logic [ACC_W-1:0]   score_total;
  logic               is_final;

  modport source (output valid, image_score, score_total, is_final, input ready);
  modport sink   (input valid, image_score, score_total, is_final, output ready);
endinterface

/* rtl/bmf1_front.sv */
// Front end: classify pixel pairs, keep saturating counts, push a snapshot per image.
module bmf1_front
  import bmf1_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  bmf1_in_if.sink   in_i,
  input  logic      full_i,
  output logic      push_o,
  output counts_t   push_data_o
);

  logic [CNT_W-1:0] tp_q, fp_q, fn_q;
  logic [CNT_W-1:0] tp_d, fp_d, fn_d;
  logic             accept;
  logic             pred_pos, pred_neg, targ_pos, targ_neg;

  assign in_i.ready = !full_i;
  assign accept     = in_i.valid && in_i.ready;

  assign pred_pos = (in_i.pred_pixel == POS_VAL);
  assign pred_neg = (in_i.pred_pixel == NEG_VAL);
  assign targ_pos = (in_i.target_pixel == POS_VAL);
  assign targ_neg = (in_i.target_pixel == NEG_VAL);

  // Counts including the current pair.
  assign tp_d = (pred_pos && targ_pos) ? sat_inc(tp_q) : tp_q;
  assign fp_d = (pred_pos && targ_neg) ? sat_inc(fp_q) : fp_q;
  assign fn_d = (pred_neg && targ_pos) ? sat_inc(fn_q) : fn_q;

  assign push_o      = accept && in_i.last_in_image;
  assign push_data_o = '{tp: tp_d, fp: fp_d, fn: fn_d, last_img: in_i.last_image};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tp_q <= '0;
      fp_q <= '0;
      fn_q <= '0;
    end else if (accept) begin
      if (in_i.last_in_image) begin
        tp_q <= '0;
        fp_q <= '0;
        fn_q <= '0;
      end else begin
        tp_q <= tp_d;
        fp_q <= fp_d;
        fn_q <= fn_d;
      end
    end
  end

  a_clear_after_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |=> (tp_q == '0) && (fp_q == '0) && (fn_q == '0))
    else $error("counters not cleared after closing pixel");

endmodule

/* rtl/bmf1_fifo.sv */
// Short queue of per-image count snapshots between front and back end.
module bmf1_fifo
  import bmf1_pkg::*;
#(
  parameter int unsigned Depth = 2
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  counts_t push_data_i,
  output logic    full_o,
  input  logic    pop_i,
  output counts_t pop_data_o,
  output logic    empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  counts_t          mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q;

  assign full_o     = (cnt_q == CntW'(Depth));
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("pop from empty queue");

endmodule

/* rtl/bmf1_back.sv */
// Back end: serial restoring divide for F1, saturating running sum, output register.
module bmf1_back
  import bmf1_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      empty_i,
  input  counts_t   pop_data_i,
  output logic      pop_o,
  bmf1_out_if.source out_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EMIT
  } state_e;

  localparam int unsigned StepW = $clog2(QUO_W);
  localparam logic [StepW-1:0] LastStep = StepW'(QUO_W - 1);

  state_e             state_q;
  logic [DEN_W-1:0]   den_q;
  logic [REM_W-1:0]   rem_q;
  logic [QUO_W-1:0]   quo_q;
  logic [StepW-1:0]   step_q;
  logic               final_q;
  logic [ACC_W-1:0]   acc_q;
  logic               valid_q;
  logic [SCORE_W-1:0] score_q;
  logic [ACC_W-1:0]   total_q;
  logic               is_final_q;

  logic [CNT_W-1:0]   tp, fp, fn;
  logic [NUM_W-1:0]   num;
  logic [DEN_W-1:0]   den;
  logic [REM_W-1:0]   rem_sh;
  logic               fits;
  logic [ACC_W:0]     sum;
  logic [ACC_W-1:0]   sum_sat;
  logic               out_free;

  assign tp  = at_least_one(pop_data_i.tp);
  assign fp  = at_least_one(pop_data_i.fp);
  assign fn  = at_least_one(pop_data_i.fn);
  assign num = {tp, 1'b0};
  assign den = DEN_W'(num) + DEN_W'(fp) + DEN_W'(fn);

  // Remainder stays below the divisor, so the top bit is free for the shift.
  assign rem_sh = {rem_q[REM_W-2:0], 1'b0};
  assign fits   = (rem_sh >= REM_W'(den_q));

  assign sum     = {1'b0, acc_q} + (ACC_W + 1)'(quo_q);
  assign sum_sat = sum[ACC_W] ? ACC_MAX : sum[ACC_W-1:0];

  assign out_free = !valid_q || out_o.ready;
  assign pop_o    = (state_q == ST_IDLE) && !empty_i;

  assign out_o.valid       = valid_q;
  assign out_o.image_score = score_q;
  assign out_o.score_total = total_q;
  assign out_o.is_final    = is_final_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      den_q      <= '0;
      rem_q      <= '0;
      quo_q      <= '0;
      step_q     <= '0;
      final_q    <= 1'b0;
      acc_q      <= '0;
      valid_q    <= 1'b0;
      score_q    <= '0;
      total_q    <= '0;
      is_final_q <= 1'b0;
    end else begin
      // Raise valid when the emit state finds the output free; drop it once taken.
      if ((state_q == ST_EMIT) && out_free) begin
        valid_q <= 1'b1;
      end else if (valid_q && out_o.ready) begin
        valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (!empty_i) begin
            den_q   <= den;
            rem_q   <= REM_W'(num);
            quo_q   <= '0;
            step_q  <= '0;
            final_q <= pop_data_i.last_img;
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          rem_q  <= fits ? rem_sh - REM_W'(den_q) : rem_sh;
          quo_q  <= {quo_q[QUO_W-2:0], fits};
          step_q <= step_q + 1'b1;
          if (step_q == LastStep) begin
            state_q <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            score_q    <= SCORE_W'(quo_q);
            total_q    <= sum_sat;
            is_final_q <= final_q;
            acc_q      <= final_q ? '0 : sum_sat;
            state_q    <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  a_valid_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(valid_q) |-> $past(state_q == ST_EMIT))
    else $error("result raised outside emit state");

  a_total_covers_score: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> (ACC_W'(score_q) <= total_q))
    else $error("running sum below image score");

endmodule

/* rtl/binary_mask_f1_score.sv */
// Top level: F1 score of binary segmentation masks, front counter plus queued divide back end.
// Throughput: one pixel pair per cycle while the queue has room; per image the back end
//   runs a load step, one divide step per bit of the 16-bit quotient and an emit step that
//   waits for a free output, and the queue holds QUEUE_DEPTH image snapshots, so input
//   stalls only when images end faster than the back end drains them.
// Reset: rst_ni asynchronous active low clears counters, running sum, queue and result valid.
module binary_mask_f1_score
  import bmf1_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 2  // image snapshots in flight, 2 or more
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  bmf1_in_if.sink    in_i,
  bmf1_out_if.source out_o
);

  // Snapshot handoff: the front pushes tp/fp/fn plus the final-image mark on the
  // closing pixel of every image and then clears its counters for the next one.
  logic    push;
  logic    full;
  logic    pop;
  logic    empty;
  counts_t push_data;
  counts_t pop_data;

  // Front: classify each transaction and count; ready drops only when the queue is full.
  bmf1_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .full_i      (full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  // Queue: decouple the per-pixel front from the per-image divide.
  bmf1_fifo #(
    .Depth (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .empty_o     (empty)
  );

  // Back: raise zero counts to one, divide 2tp by 2tp+fp+fn one quotient bit per
  // cycle, add into the saturating running sum and hold the result transaction.
  bmf1_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .empty_i    (empty),
    .pop_data_i (pop_data),
    .pop_o      (pop),
    .out_o      (out_o)
  );

endmodule

/* bench/binary_mask_f1_score_tb.sv */
// Testbench: checks F1 score results of the mask block against a built-in score predictor.
`timescale 1ns / 100ps

module binary_mask_f1_score_tb;
  import bmf1_pkg::*;

  // One pixel pair as queued for the driver. hold_for_drain makes the driver
  // wait until every expected score has come back before offering this pair.
  typedef struct {
    logic [PIX_W-1:0] pred;
    logic [PIX_W-1:0] target;
    logic             last_pix;
    logic             last_img;
    logic             hold_for_drain;
  } pixel_pair_t;

  // One expected score transaction.
  typedef struct {
    logic [SCORE_W-1:0] score;
    logic [ACC_W-1:0]   total;
    logic               is_final;
  } image_score_t;

  // Receiver behavior, switched at random stretch by stretch.
  typedef enum int {
    RX_ALWAYS,
    RX_COIN,
    RX_SPARSE
  } rx_mode_e;

  localparam int unsigned HOLD_CYCLES  = 400;  // long receiver hold-off
  localparam int unsigned NUM_HOLDS    = 2;
  localparam int unsigned HOLD_SPACING = 50;   // scores between hold-offs
  localparam int unsigned TAIL_CYCLES  = 40;   // idle wait after the last expected score
  localparam int unsigned RAND_PAIRS   = 2000;

  logic clk_i = 1'b0;
  logic rst_ni;

  bmf1_in_if  pix_if ();
  bmf1_out_if score_if ();

  binary_mask_f1_score DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (pix_if),
    .out_o  (score_if)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Stimulus waiting to be driven, and scores waiting to be seen.
  pixel_pair_t  pixel_queue[$];
  image_score_t score_queue[$];

  // Predictor state: confusion counts of the open image and the running sum.
  logic [CNT_W-1:0] tp_cnt, fp_cnt, fn_cnt;
  logic [ACC_W-1:0] score_sum;

  int unsigned n_errors;
  int unsigned n_pairs;
  int unsigned n_images;
  int unsigned n_runs;
  int unsigned n_sat_totals;
  int unsigned n_in_stalls;
  int unsigned n_scores;      // updated with nonblocking assignments only
  int unsigned hold_left;
  int unsigned holds_done;

  task automatic report_mismatch(input string msg);
    n_errors++;
    $display("ERROR %0t ns: %s", $realtime, msg);
  endtask

  // Advance the predictor by one accepted pixel pair; on a closing pixel
  // compute the image F1 and queue the expected score.
  function automatic void score_pixel_pair(input pixel_pair_t p);
    logic [63:0] tp, fp, fn, num, den, quo, sum;
    image_score_t e;
    // Count the pair first: only exact 0/255 codes move a counter.
    if (p.pred == POS_VAL && p.target == POS_VAL) begin
      if (tp_cnt != CNT_MAX) tp_cnt = tp_cnt + 1'b1;
    end else if (p.pred == POS_VAL && p.target == NEG_VAL) begin
      if (fp_cnt != CNT_MAX) fp_cnt = fp_cnt + 1'b1;
    end else if (p.pred == NEG_VAL && p.target == POS_VAL) begin
      if (fn_cnt != CNT_MAX) fn_cnt = fn_cnt + 1'b1;
    end
    if (!p.last_pix) return;
    // Raise empty counts to one so the divisor never vanishes.
    tp  = (tp_cnt == '0) ? 64'd1 : 64'(tp_cnt);
    fp  = (fp_cnt == '0) ? 64'd1 : 64'(fp_cnt);
    fn  = (fn_cnt == '0) ? 64'd1 : 64'(fn_cnt);
    num = tp << 1;
    den = num + fp + fn;
    quo = (num << 16) / den;
    sum = 64'(score_sum) + quo;
    if (sum > 64'(ACC_MAX)) sum = 64'(ACC_MAX);
    e.score    = quo[SCORE_W-1:0];
    e.total    = sum[ACC_W-1:0];
    e.is_final = p.last_img;
    score_queue.insert(score_queue.size(), e);
    if (e.total == ACC_MAX) n_sat_totals++;
    n_images++;
    tp_cnt    = '0;
    fp_cnt    = '0;
    fn_cnt    = '0;
    score_sum = p.last_img ? '0 : sum[ACC_W-1:0];
    if (p.last_img) n_runs++;
  endfunction

  task automatic add_pair(input logic [PIX_W-1:0] pred, input logic [PIX_W-1:0] target,
                          input logic last_pix, input logic last_img,
                          input logic hold_for_drain);
    pixel_pair_t p;
    p.pred           = pred;
    p.target         = target;
    p.last_pix       = last_pix;
    p.last_img       = last_img;
    p.hold_for_drain = hold_for_drain;
    pixel_queue.insert(pixel_queue.size(), p);
  endtask

  // Random image: mostly clean 0/255 masks with a per-image agreement rate,
  // some pairs of arbitrary codes, and now and then a stray final mark.
  task automatic add_random_image(input logic hold_for_drain);
    int unsigned len, agree, r;
    logic t, pr, last_img;
    logic [PIX_W-1:0] pv, tv;
    r = $urandom_range(0, 99);
    if (r < 70)      len = $urandom_range(1, 8);
    else if (r < 95) len = $urandom_range(9, 64);
    else             len = $urandom_range(65, 400);
    agree    = $urandom_range(0, 100);
    last_img = ($urandom_range(0, 5) == 0);
    for (int unsigned i = 0; i < len; i++) begin
      if ($urandom_range(0, 99) < 8) begin
        pv = 8'($urandom);
        tv = 8'($urandom);
      end else begin
        t  = 1'($urandom);
        pr = ($urandom_range(0, 99) < agree) ? t : ~t;
        pv = pr ? NEG_VAL : POS_VAL;
        tv = t  ? NEG_VAL : POS_VAL;
      end
      if (i == len - 1)
        add_pair(pv, tv, 1'b1, last_img, (i == 0) && hold_for_drain);
      else
        add_pair(pv, tv, 1'b0, ($urandom_range(0, 9) == 0), (i == 0) && hold_for_drain);
    end
  endtask

  // Driver: offer pairs in bursts of random length separated by random gaps.
  // The pair on the bus is scored the moment its transaction completes.
  pixel_pair_t cur_pair;
  int unsigned burst_left, gap_left;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_if.valid         <= 1'b0;
      pix_if.pred_pixel    <= '0;
      pix_if.target_pixel  <= '0;
      pix_if.last_in_image <= 1'b0;
      pix_if.last_image    <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (pix_if.valid && pix_if.ready) begin
        score_pixel_pair(cur_pair);
        n_pairs++;
      end
      if (pix_if.valid && !pix_if.ready) begin
        // Hold the pair steady while the block pushes back.
        n_in_stalls++;
      end else if (gap_left > 0) begin
        gap_left--;
        pix_if.valid <= 1'b0;
      end else if (pixel_queue.size() == 0 ||
                   (pixel_queue[0].hold_for_drain && score_queue.size() != 0)) begin
        pix_if.valid <= 1'b0;
      end else begin
        cur_pair = pixel_queue.pop_front();
        pix_if.pred_pixel    <= cur_pair.pred;
        pix_if.target_pixel  <= cur_pair.target;
        pix_if.last_in_image <= cur_pair.last_pix;
        pix_if.last_image    <= cur_pair.last_img;
        pix_if.valid         <= 1'b1;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          // Pick the next burst; a quarter of the time run straight on.
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
    end
  end

  // Long hold-off: after each HOLD_SPACING scores, up to NUM_HOLDS times, drop ready
  // for the length set by HOLD_CYCLES while the sender keeps offering pairs.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left  <= 0;
      holds_done <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (holds_done < NUM_HOLDS && n_scores >= (holds_done + 1) * HOLD_SPACING) begin
      hold_left  <= HOLD_CYCLES;
      holds_done <= holds_done + 1;
    end
  end

  // Monitor: compare each completed score transaction with the oldest
  // expectation, then choose ready for the next cycle.
  rx_mode_e    rx_mode;
  int unsigned rx_left;
  logic        rx_ready;
  image_score_t got, want;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      score_if.ready <= 1'b0;
      n_scores       <= 0;
      rx_mode = RX_ALWAYS;
      rx_left = 0;
    end else begin
      if (score_if.valid && score_if.ready) begin
        n_scores <= n_scores + 1;
        got.score    = score_if.image_score;
        got.total    = score_if.score_total;
        got.is_final = score_if.is_final;
        if (score_queue.size() == 0) begin
          report_mismatch($sformatf("unexpected score %0d total %0d final %0b",
                                    got.score, got.total, got.is_final));
        end else begin
          want = score_queue.pop_front();
          if (got.score !== want.score)
            report_mismatch($sformatf("image_score %0d, predicted %0d",
                                      got.score, want.score));
          if (got.total !== want.total)
            report_mismatch($sformatf("score_total %0d, predicted %0d",
                                      got.total, want.total));
          if (got.is_final !== want.is_final)
            report_mismatch($sformatf("is_final %0b, predicted %0b",
                                      got.is_final, want.is_final));
        end
      end
      if (rx_left == 0) begin
        rx_mode = rx_mode_e'($urandom_range(0, 2));
        rx_left = $urandom_range(50, 400);
      end else begin
        rx_left--;
      end
      case (rx_mode)
        RX_ALWAYS: rx_ready = 1'b1;
        RX_COIN:   rx_ready = 1'($urandom);
        default:   rx_ready = ($urandom_range(0, 7) == 0);
      endcase
      score_if.ready <= rx_ready && (hold_left == 0);
    end
  end

  // Run limit, far above the slowest correct run.
  initial begin
    #6_000_000;
    $display("binary_mask_f1_score: mismatch");
    $finish;
  end

  initial begin
    int unsigned queued;
    pix_if.valid         = 1'b0;
    pix_if.pred_pixel    = '0;
    pix_if.target_pixel  = '0;
    pix_if.last_in_image = 1'b0;
    pix_if.last_image    = 1'b0;
    score_if.ready       = 1'b0;
    rst_ni    = 1'b0;
    tp_cnt    = '0;
    fp_cnt    = '0;
    fn_cnt    = '0;
    score_sum = '0;
    n_errors = 0; n_pairs = 0; n_images = 0; n_runs = 0;
    n_sat_totals = 0; n_in_stalls = 0;

    // Directed: one-pixel images, the all-empty image, each confusion class.
    add_pair(POS_VAL, POS_VAL, 1'b1, 1'b0, 1'b0);
    add_pair(NEG_VAL, NEG_VAL, 1'b1, 1'b0, 1'b0);
    add_pair(POS_VAL, NEG_VAL, 1'b0, 1'b0, 1'b0);
    add_pair(NEG_VAL, POS_VAL, 1'b0, 1'b0, 1'b0);
    add_pair(POS_VAL, POS_VAL, 1'b1, 1'b0, 1'b0);
    // Stray final mark away from the closing pixel must be ignored.
    add_pair(POS_VAL, POS_VAL, 1'b0, 1'b1, 1'b0);
    add_pair(POS_VAL, POS_VAL, 1'b0, 1'b0, 1'b0);
    add_pair(POS_VAL, POS_VAL, 1'b1, 1'b0, 1'b0);
    // Codes other than 0/255, near misses and alternating bits, then close the run.
    add_pair(8'd1,    POS_VAL, 1'b0, 1'b0, 1'b0);
    add_pair(POS_VAL, 8'd1,    1'b0, 1'b0, 1'b0);
    add_pair(8'd254,  NEG_VAL, 1'b0, 1'b0, 1'b0);
    add_pair(NEG_VAL, 8'd254,  1'b0, 1'b0, 1'b0);
    add_pair(8'hAA,   8'h55,   1'b0, 1'b0, 1'b0);
    add_pair(8'h55,   8'hAA,   1'b0, 1'b0, 1'b0);
    add_pair(POS_VAL, POS_VAL, 1'b1, 1'b1, 1'b0);
    // A fresh run: false negatives only, then false positives only closing it.
    add_pair(NEG_VAL, POS_VAL, 1'b0, 1'b0, 1'b0);
    add_pair(NEG_VAL, POS_VAL, 1'b1, 1'b0, 1'b0);
    add_pair(POS_VAL, NEG_VAL, 1'b1, 1'b1, 1'b0);

    // Saturate the running sum: 70 one-pixel images score one half each,
    // well past the top of the accumulator; wait for the bench to drain first.
    for (int unsigned i = 0; i < 70; i++)
      add_pair(POS_VAL, POS_VAL, 1'b1, 1'b0, (i == 0));
    add_pair(POS_VAL, POS_VAL, 1'b1, 1'b1, 1'b0);

    // Random images; pause for a full drain before the first and now and then.
    queued = pixel_queue.size();
    add_random_image(1'b1);
    while (pixel_queue.size() - queued < RAND_PAIRS)
      add_random_image($urandom_range(0, 49) == 0);

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pixel_queue.size() != 0 || pix_if.valid || score_queue.size() != 0)
      @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Drove %0d pixel pairs in %0d images over %0d runs; %0d totals hit the ceiling.",
             n_pairs, n_images, n_runs, n_sat_totals);
    $display("Input held back by the block for %0d cycles; %0d mismatches.",
             n_in_stalls, n_errors);
    if (n_errors == 0 && score_queue.size() == 0) begin
      $display("binary_mask_f1_score: match");
    end else begin
      $display("binary_mask_f1_score: mismatch");
    end
    $finish;
  end

endmodule
